// File: design/tlbpt_pkg.sv
package tlbpt_pkg;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_FILL  = 2'd2,
    OUT_ERROR = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    REG_ENTRIES = 2'd0,
    REG_PAGE    = 2'd1,
    REG_MODE    = 2'd2,
    REG_NONE    = 2'd3
  } reg_index_t;

  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_FILL      = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_PROMOTE,
    ST_FIND_EMPTY,
    ST_SHIFT,
    ST_MUL,
    ST_MUL_ADD,
    ST_OUT
  } state_t;

endpackage

// File: design/tlb_page_translation.sv
// TLB page translation block.
// Input channel (in_valid/in_ready) carries one request: action 0 translates
// logical_address for process_id, action 1 fills the pending miss with
// frame_number (or reports memory_failed). Output channel (out_valid/
// out_ready) returns exactly one result per request. Configuration writes
// (cfg_valid/cfg_ready, cfg_index, cfg_data) set entries_in_use, page_bytes
// and replacement_mode; writing entries_in_use flushes the TLB.
// A translate divides logical_address by page_bytes (a setup step, a start
// step, then the quotient bits), searches the TLB slot by slot, moves slots
// on an LRU promotion and, on a hit, ends with a multiply-add; a page size
// of zero gives an error result without a division. A fill scans for an
// empty slot, shifts the table down when it is full and ends with the
// multiply-add; with no pending miss or on memory_failed it gives an error.
// The table is walked one entry per cycle through a single read port. One
// item is in work at a time; in_ready is low from acceptance until the
// result is transferred. A stalled receiver holds the result in the output
// register and the block waits. Synchronous reset empties the TLB, drops
// any pending miss and restores the configuration defaults (16 entries,
// 4096 byte pages, FIFO order).
module tlb_page_translation
  import tlbpt_pkg::*;
#(
  parameter int TLB_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] logical_address,
  input  logic [15:0] process_id,
  input  logic [31:0] frame_number,
  input  logic        memory_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic [31:0] physical_address,
  output logic [31:0] page_requested,
  output logic [15:0] process_requested,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int CW = $clog2(TLB_DEPTH + 1);

  // Configuration registers.
  logic [5:0]  entries_in_use;
  logic [31:0] page_bytes;
  logic        replacement_mode;

  // Entry storage: valid bits in flops, payload in a memory.
  logic [TLB_DEPTH-1:0] entry_valid, entry_valid_next;
  logic [79:0] mem [TLB_DEPTH];
  logic [79:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  logic [79:0] wr_data;

  // Pending miss.
  logic        pending_valid;
  logic [15:0] pending_process;
  logic [31:0] pending_page;
  logic [31:0] pending_offset;

  // Sequencer registers.
  state_t      state, state_next;
  logic        req_action;
  logic [15:0] req_pid;
  logic [31:0] req_frame;
  logic        req_failed;
  logic [31:0] page, offset;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] slots;
  logic        rd_pending;
  logic [79:0] held;
  logic [31:0] mul_a, mul_b;
  logic [31:0] product, add_term;

  logic        div_start, div_done;
  logic        div_busy;
  logic [31:0] div_q, div_r;
  logic [31:0] logical_address_q;

  tlbpt_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (logical_address_q),
    .divisor   (page_bytes),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign div_start = (state == ST_DIV) && !div_busy && !div_done && !rd_pending;

  always_comb begin
    if ({26'd0, entries_in_use} > TLB_DEPTH) slots = CW'(TLB_DEPTH);
    else slots = CW'(entries_in_use);
  end

  // Memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // The entry at the current index plus one for shifting.
  logic [CW-1:0] idx_p1;
  assign idx_p1 = idx + CW'(1);
  logic hit_now;
  assign hit_now = entry_valid[idx[IW-1:0]] && rd_data[79:64] == req_pid &&
                   rd_data[63:32] == page;

  // Next state, memory access and valid updates.
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    rd_addr          = idx[IW-1:0];
    wr_en            = 1'b0;
    wr_addr          = idx[IW-1:0];
    wr_data          = rd_data;
    entry_valid_next = entry_valid;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (action == ACT_TRANSLATE) state_next = ST_DIV;
          else state_next = ST_FIND_EMPTY;
          idx_next = '0;
          rd_addr  = '0;
        end
      end
      ST_DIV: begin
        if (page_bytes == '0 && !div_busy && !div_done) begin
          state_next = ST_IDLE;
        end else if (div_done) begin
          idx_next = '0;
          rd_addr  = '0;
          state_next = (slots == '0) ? ST_OUT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit_now) begin
          state_next = ST_MUL;
          if (replacement_mode) begin
            state_next = ST_PROMOTE;
            rd_addr    = idx_p1[IW-1:0];
          end
        end else if (idx_p1 >= slots) begin
          state_next = ST_OUT;
        end else begin
          idx_next = idx_p1;
          rd_addr  = idx_p1[IW-1:0];
        end
      end
      ST_PROMOTE: begin
        // held has the hit entry; rd_data has the slot after idx.
        if (idx_p1 < slots && entry_valid[idx_p1[IW-1:0]]) begin
          wr_en    = 1'b1;
          wr_data  = rd_data;
          idx_next = idx_p1;
          rd_addr  = (idx_p1 + CW'(1) < CW'(TLB_DEPTH)) ?
                     IW'(idx_p1 + CW'(1)) : idx_p1[IW-1:0];
        end else begin
          wr_en      = 1'b1;
          wr_data    = held;
          state_next = ST_MUL;
        end
      end
      ST_FIND_EMPTY: begin
        if (!pending_valid || req_failed) begin
          state_next = ST_OUT;
        end else if (slots == '0) begin
          state_next = ST_MUL;
        end else if (!entry_valid[idx[IW-1:0]]) begin
          wr_en   = 1'b1;
          wr_data = {pending_process, pending_page, req_frame};
          entry_valid_next[idx[IW-1:0]] = 1'b1;
          state_next = ST_MUL;
        end else if (idx_p1 >= slots) begin
          idx_next   = '0;
          rd_addr    = (slots > CW'(1)) ? IW'(1) : '0;
          state_next = ST_SHIFT;
        end else begin
          idx_next = idx_p1;
        end
      end
      ST_SHIFT: begin
        // Table is full: shift down and append at the back.
        if (idx_p1 >= slots) begin
          wr_en   = 1'b1;
          wr_data = {pending_process, pending_page, req_frame};
          state_next = ST_MUL;
        end else begin
          wr_en    = 1'b1;
          wr_data  = rd_data;
          idx_next = idx_p1;
          rd_addr  = (idx_p1 + CW'(1) < CW'(TLB_DEPTH)) ?
                     IW'(idx_p1 + CW'(1)) : idx_p1[IW-1:0];
        end
      end
      ST_MUL:     state_next = ST_MUL_ADD;
      ST_MUL_ADD: state_next = ST_IDLE;
      ST_OUT:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase

    // Writing the entry count flushes the table.
    if (cfg_valid && cfg_ready && reg_index_t'(cfg_index) == REG_ENTRIES) begin
      entry_valid_next = '0;
    end
  end

  // Multiplier operands: hit frame or filled frame.
  always_comb begin
    mul_a = req_action ? req_frame : held[31:0];
    mul_b = page_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      entry_valid      <= '0;
      pending_valid    <= 1'b0;
      pending_process  <= '0;
      pending_page     <= '0;
      pending_offset   <= '0;
      entries_in_use   <= 6'd16;
      page_bytes       <= 32'd4096;
      replacement_mode <= 1'b0;
      out_valid        <= 1'b0;
      rd_pending       <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      entry_valid <= entry_valid_next;
      rd_pending  <= in_valid && in_ready;

      // Configuration transfer.
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ENTRIES: entries_in_use <= cfg_data[5:0];
          REG_PAGE: page_bytes       <= cfg_data;
          REG_MODE: replacement_mode <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_action        <= action;
            req_pid           <= process_id;
            req_frame         <= frame_number;
            req_failed        <= memory_failed;
            logical_address_q <= logical_address;
          end
        end
        ST_DIV: begin
          if (page_bytes == '0 && !div_busy && !div_done) begin
            outcome          <= OUT_ERROR;
            physical_address <= '0;
            page_requested   <= '0;
            process_requested <= '0;
            out_valid        <= 1'b1;
          end else if (div_done) begin
            page   <= div_q;
            offset <= div_r;
          end
        end
        ST_SEARCH: begin
          held <= rd_data;
          if (hit_now) add_term <= offset;
        end
        ST_PROMOTE: begin
          if (!(idx_p1 < slots && entry_valid[idx_p1[IW-1:0]])) held <= held;
        end
        ST_FIND_EMPTY: begin
          add_term <= pending_offset;
          // The pending request is consumed once the scan is over.
          if (state_next != ST_FIND_EMPTY) pending_valid <= 1'b0;
          if (!pending_valid || req_failed) begin
            outcome <= OUT_ERROR;
          end
        end
        ST_MUL: product <= mul_a * mul_b;
        ST_MUL_ADD: begin
          physical_address  <= product + add_term;
          page_requested    <= '0;
          process_requested <= '0;
          outcome           <= req_action ? OUT_FILL : OUT_HIT;
          out_valid         <= 1'b1;
        end
        ST_OUT: begin
          // Miss (translate) or error (fill) result.
          if (req_action == ACT_TRANSLATE) begin
            outcome           <= OUT_MISS;
            page_requested    <= page;
            process_requested <= req_pid;
            pending_valid     <= 1'b1;
            pending_process   <= req_pid;
            pending_page      <= page;
            pending_offset    <= offset;
          end else begin
            outcome           <= OUT_ERROR;
            page_requested    <= '0;
            process_requested <= '0;
          end
          physical_address <= '0;
          out_valid        <= 1'b1;
        end
        default: ;
      endcase

      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input ready while an item is in work");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while the receiver stalls");
  a_miss_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == OUT_MISS) |-> pending_valid)
    else $error("miss reported without a pending request");
  a_fill_clears: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && outcome == OUT_FILL) |-> !pending_valid)
    else $error("fill left the pending request set");
`endif

endmodule

// File: design/tlbpt_divider.sv
module tlbpt_divider
  import tlbpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [5:0]  count;
  logic [32:0] rem_trial;

  // One quotient bit per cycle, restoring division.
  assign rem_trial = {remainder, quotient[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == 6'd1);
      if (start) begin
        busy      <= 1'b1;
        count     <= 6'd32;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (rem_trial[32]) begin
          remainder <= {remainder[30:0], quotient[31]};
          quotient  <= {quotient[30:0], 1'b0};
        end else begin
          remainder <= rem_trial[31:0];
          quotient  <= {quotient[30:0], 1'b1};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != 6'd0)
    else $error("divider busy with zero count");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

// File: sim/tlb_translation_checker.sv
module tlb_translation_checker
  import tlbpt_pkg::*;
#(
  parameter int TLB_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [31:0] logical_address,
  input  logic [15:0] process_id,
  input  logic [31:0] frame_number,
  input  logic        memory_failed,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  outcome,
  input  logic [31:0] physical_address,
  input  logic [15:0] process_requested,
  input  logic [31:0] page_requested,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] phys;
    logic [31:0] page;
    logic [15:0] proc_id;
  } xlat_result_t;

  typedef struct packed {
    logic        used;
    logic [15:0] proc_id;
    logic [31:0] page;
    logic [31:0] frame;
  } tlb_slot_t;

  xlat_result_t expected_results[$];

  // Shadow copy of the translation state.
  tlb_slot_t   slots[TLB_DEPTH];
  logic [5:0]  entry_count;
  logic [31:0] page_len;
  logic        lru_mode;
  logic        miss_held;
  logic [15:0] miss_proc;
  logic [31:0] miss_page;
  logic [31:0] miss_offset;

  function automatic int active_slots();
    return (entry_count > TLB_DEPTH) ? TLB_DEPTH : int'(entry_count);
  endfunction

  // Move a hit entry behind the last valid entry of the packed front part.
  function automatic void move_to_back(int idx, int n);
    int last;
    tlb_slot_t keep;
    last = idx;
    keep = slots[idx];
    while (last + 1 < n && slots[last + 1].used) last++;
    for (int i = idx; i < last; i++) slots[i] = slots[i + 1];
    slots[last] = keep;
  endfunction

  function automatic void add_entry(logic [15:0] p, logic [31:0] pg, logic [31:0] fr);
    int n;
    n = active_slots();
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      if (!slots[i].used) begin
        slots[i] = {1'b1, p, pg, fr};
        return;
      end
    end
    for (int i = 0; i + 1 < n; i++) slots[i] = slots[i + 1];
    slots[n - 1] = {1'b1, p, pg, fr};
  endfunction

  function automatic xlat_result_t translate_item(logic act, logic [31:0] la,
      logic [15:0] pid, logic [31:0] fr, logic failed);
    xlat_result_t r;
    logic [31:0] pg, off;
    int n;
    logic found;
    r = '{kind: OUT_ERROR, phys: '0, page: '0, proc_id: '0};
    if (act == ACT_TRANSLATE) begin
      if (page_len != 0) begin
        pg = la / page_len;
        off = la % page_len;
        n = active_slots();
        found = 1'b0;
        for (int i = 0; i < n && !found; i++) begin
          if (slots[i].used && slots[i].proc_id == pid && slots[i].page == pg) begin
            r.phys = slots[i].frame * page_len + off;
            if (lru_mode) move_to_back(i, n);
            found = 1'b1;
          end
        end
        if (found) begin
          r.kind = OUT_HIT;
        end else begin
          r.kind = OUT_MISS;
          r.page = pg;
          r.proc_id = pid;
          miss_held = 1'b1;
          miss_proc = pid;
          miss_page = pg;
          miss_offset = off;
        end
      end
    end else if (miss_held) begin
      miss_held = 1'b0;
      if (!failed) begin
        add_entry(miss_proc, miss_page, fr);
        r.phys = fr * page_len + miss_offset;
        r.kind = OUT_FILL;
      end
    end
    return r;
  endfunction

  assign pending_results = expected_results.size();

  always @(posedge clk) begin
    xlat_result_t want;
    if (rst) begin
      for (int i = 0; i < TLB_DEPTH; i++) slots[i] = '0;
      entry_count = 6'd16;
      page_len = 32'd4096;
      lru_mode = 1'b0;
      miss_held = 1'b0;
      miss_proc = '0;
      miss_page = '0;
      miss_offset = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // Register writes, then input transfers, then result comparison.
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ENTRIES: begin
            entry_count = cfg_data[5:0];
            for (int i = 0; i < TLB_DEPTH; i++) slots[i].used = 1'b0;
          end
          REG_PAGE: begin
            page_len = cfg_data;
          end
          REG_MODE: begin
            lru_mode = cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(translate_item(action, logical_address,
            process_id, frame_number, memory_failed));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer, outcome %0d", outcome);
        end else begin
          want = expected_results.pop_front();
          if (outcome !== want.kind || physical_address !== want.phys ||
              page_requested !== want.page || process_requested !== want.proc_id) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: exp %0d %h %h %h, got %0d %h %h %h",
                       want.kind, want.phys, want.page, want.proc_id,
                       outcome, physical_address, page_requested, process_requested);
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_tlb_page_translation.sv
module tb_tlb_page_translation
  import tlbpt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [31:0] logical_address;
  logic [15:0] process_id;
  logic [31:0] frame_number;
  logic        memory_failed;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  outcome;
  logic [31:0] physical_address;
  logic [31:0] page_requested;
  logic [15:0] process_requested;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_results;
  int          idle_cycles;

  // Recently used process/address pairs, replayed to produce hits.
  logic [15:0] seen_proc[$];
  logic [31:0] seen_addr[$];

  tlb_page_translation i_dut (.*);

  tlb_translation_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int random_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // Receiver: random stalls, with long stretches of no readiness.
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      mode = $urandom_range(0, 99);
      if (mode >= 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 100)) @(posedge clk);
      end else if (mode < 15) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_item(logic act, logic [31:0] la, logic [15:0] pid,
                           logic [31:0] fr, logic failed);
    int gap;
    in_valid <= 1'b1;
    action <= act;
    logical_address <= la;
    process_id <= pid;
    frame_number <= fr;
    memory_failed <= failed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_TRANSLATE) begin
      seen_proc.push_back(pid);
      seen_addr.push_back(la);
      if (seen_proc.size() > 40) begin
        void'(seen_proc.pop_front());
        void'(seen_addr.pop_front());
      end
    end
    // With no gap the next item follows at once and keeps valid high.
    gap = random_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly miss-then-fill pairs and replays of known pages, some noise.
  task automatic random_phase(int count, logic [15:0] pid_span, logic [31:0] addr_span);
    logic [31:0] la;
    logic [15:0] pid;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 35 && seen_proc.size() > 0) begin
        k = $urandom_range(0, seen_proc.size() - 1);
        send_item(ACT_TRANSLATE, seen_addr[k] ^ ($urandom & 32'h7), seen_proc[k],
                  $urandom, 1'($urandom));
      end else if (k < 90) begin
        la = (addr_span == 0) ? $urandom : $urandom_range(0, addr_span);
        pid = 16'($urandom_range(0, pid_span));
        send_item(ACT_TRANSLATE, la, pid, $urandom, 1'($urandom));
        send_item(ACT_FILL, $urandom, 16'($urandom), $urandom,
                  ($urandom_range(0, 9) == 0));
      end else begin
        send_item(ACT_FILL, $urandom, 16'($urandom), $urandom, 1'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_TRANSLATE;
    logical_address = '0;
    process_id = '0;
    frame_number = '0;
    memory_failed = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ENTRIES;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill with no miss pending, miss, fill, hit, failure, extremes.
    send_item(ACT_FILL, '0, '0, 32'h1234, 1'b0);
    send_item(ACT_TRANSLATE, 32'hFFFF_FFFF, 16'hFFFF, '0, 1'b1);
    send_item(ACT_FILL, '0, '0, 32'hFFFF_FFFF, 1'b0);
    send_item(ACT_TRANSLATE, 32'hFFFF_F000, 16'hFFFF, '0, 1'b0);
    send_item(ACT_TRANSLATE, 32'h0000_0000, 16'h0000, '0, 1'b0);
    send_item(ACT_FILL, '0, '0, '0, 1'b1);
    send_item(ACT_TRANSLATE, 32'h0000_0ABC, 16'h0000, '0, 1'b0);
    send_item(ACT_TRANSLATE, 32'h5555_5555, 16'h00AA, '0, 1'b0);
    send_item(ACT_TRANSLATE, 32'hAAAA_AAAA, 16'h5500, '0, 1'b0);
    send_item(ACT_FILL, '0, '0, 32'hA5A5_5A5A, 1'b0);
    send_item(ACT_TRANSLATE, 32'hAAAA_A000, 16'h5500, '0, 1'b0);
    quiesce();

    // Page size zero gives errors; then one-byte pages.
    write_reg(REG_PAGE, 32'd0);
    send_item(ACT_TRANSLATE, 32'h1234_5678, 16'h1, '0, 1'b0);
    send_item(ACT_FILL, '0, '0, 32'h10, 1'b0);
    quiesce();
    write_reg(REG_PAGE, 32'd1);
    write_reg(REG_ENTRIES, 32'd0);
    send_item(ACT_TRANSLATE, 32'h10, 16'h2, '0, 1'b0);
    send_item(ACT_FILL, '0, '0, 32'h77, 1'b0);
    send_item(ACT_TRANSLATE, 32'h10, 16'h2, '0, 1'b0);
    quiesce();

    // Random phases over several table sizes, page sizes and orders.
    write_reg(REG_ENTRIES, 32'd2);
    write_reg(REG_PAGE, 32'd256);
    write_reg(REG_MODE, 32'd1);
    random_phase(40, 16'd3, 32'h0000_0FFF);
    quiesce();
    write_reg(REG_ENTRIES, 32'd63);
    write_reg(REG_PAGE, 32'hFFFF_FFFF);
    write_reg(REG_MODE, 32'd0);
    random_phase(30, 16'hFFFF, 32'd0);
    quiesce();
    write_reg(REG_ENTRIES, 32'd32);
    write_reg(REG_PAGE, 32'd4096);
    write_reg(REG_MODE, 32'd1);
    random_phase(50, 16'd7, 32'h0003_FFFF);
    quiesce();
    write_reg(REG_ENTRIES, 32'd1);
    write_reg(REG_PAGE, $urandom_range(1, 5000));
    random_phase(30, 16'd2, 32'h0000_FFFF);
    quiesce();
    write_reg(REG_ENTRIES, 32'd8);
    write_reg(REG_PAGE, 32'h8000_0000);
    write_reg(REG_MODE, 32'd0);
    random_phase(40, 16'hFFFF, 32'd0);
    quiesce();
    write_reg(REG_ENTRIES, 32'd0);
    random_phase(20, 16'd1, 32'h0000_FFFF);
    quiesce();
    write_reg(REG_ENTRIES, 32'd33);
    write_reg(REG_PAGE, 32'd512);
    write_reg(REG_MODE, 32'd1);
    random_phase(40, 16'd5, 32'h0001_FFFF);

    quiesce();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
